### sv/tmds_pkg.sv
// Package: shared types, codes and constants of the timer deadline scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tmds_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int TIME_BITS_DEF  = 64;
	localparam int MAX_FIRE       = 16;
	localparam int FIRE_CNT_BITS  = $clog2(MAX_FIRE + 1);
	localparam int ORDER_BITS     = 64;

	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_STOP   = 3'd1;
	localparam logic [2:0] MODE_AGAIN  = 3'd2;
	localparam logic [2:0] MODE_SETREP = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;

	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [31:0] TIMEOUT_CAP  = 32'h7fff_ffff;
	localparam logic [31:0] TIMEOUT_NONE = 32'hffff_ffff;

	typedef enum logic [2:0] {
		OP_START,
		OP_STOP,
		OP_AGAIN,
		OP_SETREP,
		OP_TICK,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DECIDE,
		ST_FIRE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  slot;
		logic [63:0] amount;   // delay for start, now for tick
		logic [63:0] rep;
	} cmd_t;

endpackage
`default_nettype wire

### sv/tmds_if.sv
// Interfaces: input and result channels of the timer deadline scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface tmds_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [3:0]  slot;
	logic [63:0] delay;
	logic [63:0] repeat_value;
	logic [63:0] now;
	modport source(output valid, mode, slot, delay, repeat_value, now, input ready);
	modport sink(input valid, mode, slot, delay, repeat_value, now, output ready);
endinterface

interface tmds_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [3:0]         fired_slot;
	logic signed [31:0] next_timeout;
	logic               last;
	modport source(output valid, kind, fired_slot, next_timeout, last, input ready);
	modport sink(input valid, kind, fired_slot, next_timeout, last, output ready);
endinterface
`default_nettype wire

### sv/tmds_front.sv
// Front end: accept transactions, decode the mode and queue commands.
`timescale 1ns / 1ps
`default_nettype none
module tmds_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tmds_in_if.sink        cmd,
	output tmds_pkg::cmd_t q_cmd,
	output logic           q_valid,
	input  wire logic      q_pop
);
	tmds_pkg::cmd_t dec;
	tmds_pkg::cmd_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	always_comb begin
		dec.slot   = cmd.slot;
		dec.amount = (cmd.mode == tmds_pkg::MODE_TICK) ? cmd.now : cmd.delay;
		dec.rep    = cmd.repeat_value;
		case (cmd.mode)
			tmds_pkg::MODE_START:  dec.op = tmds_pkg::OP_START;
			tmds_pkg::MODE_STOP:   dec.op = tmds_pkg::OP_STOP;
			tmds_pkg::MODE_AGAIN:  dec.op = tmds_pkg::OP_AGAIN;
			tmds_pkg::MODE_SETREP: dec.op = tmds_pkg::OP_SETREP;
			tmds_pkg::MODE_TICK:   dec.op = tmds_pkg::OP_TICK;
			default:               dec.op = tmds_pkg::OP_NONE;
		endcase
	end

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != 2'd0);
	assign q_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop && q_valid) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule
`default_nettype wire

### sv/tmds_back.sv
// Back end: slot store, earliest-deadline scan, expiry sequencing and result register.
`timescale 1ns / 1ps
`default_nettype none
module tmds_back #(
	parameter int SLOT_COUNT = tmds_pkg::SLOT_COUNT_DEF,
	parameter int TIME_BITS  = tmds_pkg::TIME_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tmds_pkg::cmd_t q_cmd,
	input  wire logic           q_valid,
	output logic                q_pop,
	tmds_out_if.source          rsp
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FB = tmds_pkg::FIRE_CNT_BITS;
	localparam int OB = tmds_pkg::ORDER_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	tmds_pkg::state_t state_q, state_d;
	tmds_pkg::cmd_t   cmd_q;

	logic [TIME_BITS-1:0] deadline_q [SLOT_COUNT];
	logic [TIME_BITS-1:0] interval_q [SLOT_COUNT];
	logic [OB-1:0]        order_q    [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] armed_q, ever_q;

	logic [TIME_BITS-1:0] cur_q;
	logic [OB-1:0]        order_cnt_q;
	logic [IW-1:0]        scan_idx_q, best_idx_q;
	logic                 best_ok_q;
	logic [TIME_BITS-1:0] best_dl_q;
	logic [OB-1:0]        best_so_q;
	logic [FB-1:0]        fire_cnt_q;
	logic                 pending_q;
	logic [1:0]           kind_q;
	logic [3:0]           rslot_q;
	logic                 rlast_q;

	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [3:0]           out_slot_q;
	logic [31:0]          out_to_q;
	logic                 out_last_q;

	logic                 slot_ok;
	logic [IW-1:0]        cmd_idx, rd_idx;
	logic [TIME_BITS-1:0] rd_dl, rd_iv, arm_d, arm_val;
	logic [OB-1:0]        rd_so;
	logic                 rd_armed, rd_ever;
	logic [TIME_BITS:0]   sum;
	logic                 do_arm, do_disarm, do_setiv, out_load, due, more;
	logic [TIME_BITS-1:0] diff;
	logic [31:0]          timeout;

	assign slot_ok  = (32'(cmd_q.slot) < 32'(SLOT_COUNT));
	assign cmd_idx  = IW'(cmd_q.slot);
	assign rd_idx   = (state_q == tmds_pkg::ST_EXEC) ? cmd_idx :
	                  (state_q == tmds_pkg::ST_FIRE) ? best_idx_q : scan_idx_q;
	assign rd_dl    = deadline_q[rd_idx];
	assign rd_iv    = interval_q[rd_idx];
	assign rd_so    = order_q[rd_idx];
	assign rd_armed = armed_q[rd_idx];
	assign rd_ever  = ever_q[rd_idx];

	// saturating add of current time and the arm distance
	assign arm_d   = (cmd_q.op == tmds_pkg::OP_START && state_q == tmds_pkg::ST_EXEC) ?
	                 TIME_BITS'(cmd_q.amount) : rd_iv;
	assign sum     = {1'b0, cur_q} + {1'b0, arm_d};
	assign arm_val = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

	assign due  = best_ok_q && (best_dl_q <= cur_q);
	assign more = due && (fire_cnt_q < FB'(tmds_pkg::MAX_FIRE));
	assign diff = best_dl_q - cur_q;

	always_comb begin
		if (!best_ok_q) begin
			timeout = tmds_pkg::TIMEOUT_NONE;
		end else if (best_dl_q <= cur_q) begin
			timeout = 32'd0;
		end else if (64'(diff) > 64'(tmds_pkg::TIMEOUT_CAP)) begin
			timeout = tmds_pkg::TIMEOUT_CAP;
		end else begin
			timeout = 32'(diff);
		end
	end

	assign out_load = (state_q == tmds_pkg::ST_EMIT) && (!out_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmds_pkg::ST_IDLE:   if (q_valid) state_d = tmds_pkg::ST_EXEC;
			tmds_pkg::ST_EXEC:   state_d = tmds_pkg::ST_SCAN;
			tmds_pkg::ST_SCAN:   if (scan_idx_q == LAST_IDX) state_d = tmds_pkg::ST_DECIDE;
			tmds_pkg::ST_DECIDE: begin
				if (cmd_q.op == tmds_pkg::OP_TICK && !pending_q && due)
					state_d = tmds_pkg::ST_FIRE;
				else
					state_d = tmds_pkg::ST_EMIT;
			end
			tmds_pkg::ST_FIRE:   state_d = tmds_pkg::ST_SCAN;
			tmds_pkg::ST_EMIT: begin
				if (out_load) state_d = rlast_q ? tmds_pkg::ST_IDLE : tmds_pkg::ST_FIRE;
			end
			default:             state_d = tmds_pkg::ST_IDLE;
		endcase
	end

	// store controls
	always_comb begin
		q_pop     = 1'b0;
		do_arm    = 1'b0;
		do_disarm = 1'b0;
		do_setiv  = 1'b0;
		case (state_q)
			tmds_pkg::ST_IDLE: q_pop = q_valid;
			tmds_pkg::ST_EXEC: begin
				if (slot_ok) begin
					case (cmd_q.op)
						tmds_pkg::OP_START: begin
							do_setiv = 1'b1;
							do_arm   = 1'b1;
						end
						tmds_pkg::OP_STOP:   do_disarm = 1'b1;
						tmds_pkg::OP_AGAIN:  do_arm = rd_ever && (rd_iv != '0);
						tmds_pkg::OP_SETREP: do_setiv = 1'b1;
						default: ;
					endcase
				end
			end
			tmds_pkg::ST_FIRE: begin
				do_disarm = 1'b1;
				do_arm    = (rd_iv != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_setiv) interval_q[rd_idx] <= TIME_BITS'(cmd_q.rep);
		if (do_arm) begin
			deadline_q[rd_idx] <= arm_val;
			order_q[rd_idx]    <= order_cnt_q;
		end
		if (state_q == tmds_pkg::ST_IDLE && q_valid) cmd_q <= q_cmd;
		if (out_load) begin
			out_kind_q <= kind_q;
			out_slot_q <= rslot_q;
			out_to_q   <= timeout;
			out_last_q <= rlast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmds_pkg::ST_IDLE;
			armed_q     <= '0;
			ever_q      <= '0;
			cur_q       <= '0;
			order_cnt_q <= '0;
			scan_idx_q  <= '0;
			best_idx_q  <= '0;
			best_ok_q   <= 1'b0;
			best_dl_q   <= '0;
			best_so_q   <= '0;
			fire_cnt_q  <= '0;
			pending_q   <= 1'b0;
			kind_q      <= tmds_pkg::KIND_DONE;
			rslot_q     <= '0;
			rlast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a rearm keeps the slot armed
			if (do_disarm || do_arm) armed_q[rd_idx] <= do_arm;
			if (do_arm) begin
				ever_q[rd_idx]  <= 1'b1;
				order_cnt_q     <= order_cnt_q + 1'b1;
			end
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			case (state_q)
				tmds_pkg::ST_IDLE: begin
					fire_cnt_q <= '0;
					pending_q  <= 1'b0;
				end
				tmds_pkg::ST_EXEC: begin
					scan_idx_q <= '0;
					best_ok_q  <= 1'b0;
					rlast_q    <= 1'b1;
					if (cmd_q.op == tmds_pkg::OP_TICK) begin
						cur_q   <= TIME_BITS'(cmd_q.amount);
						kind_q  <= tmds_pkg::KIND_DONE;
						rslot_q <= '0;
					end else begin
						rslot_q <= cmd_q.slot;
						kind_q  <= (slot_ok && cmd_q.op == tmds_pkg::OP_AGAIN && !rd_ever) ?
						           tmds_pkg::KIND_ERROR : tmds_pkg::KIND_DONE;
					end
				end
				tmds_pkg::ST_SCAN: begin
					if (rd_armed && (!best_ok_q || rd_dl < best_dl_q ||
					    (rd_dl == best_dl_q && rd_so < best_so_q))) begin
						best_ok_q  <= 1'b1;
						best_idx_q <= scan_idx_q;
						best_dl_q  <= rd_dl;
						best_so_q  <= rd_so;
					end
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				tmds_pkg::ST_DECIDE: begin
					// a firing is last unless another one is due within the limit
					if (pending_q) rlast_q <= !more;
				end
				tmds_pkg::ST_FIRE: begin
					fire_cnt_q <= fire_cnt_q + 1'b1;
					pending_q  <= 1'b1;
					kind_q     <= tmds_pkg::KIND_EXPIRED;
					rslot_q    <= 4'(best_idx_q);
					scan_idx_q <= '0;
					best_ok_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.fired_slot   = out_slot_q;
	assign rsp.next_timeout = out_to_q;
	assign rsp.last         = out_last_q;

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FB'(tmds_pkg::MAX_FIRE))
		else $error("fire count beyond limit");
	a_fire_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmds_pkg::ST_FIRE) |-> (best_ok_q && armed_q[best_idx_q]))
		else $error("firing a slot that is not armed");
	a_pending_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (cmd_q.op == tmds_pkg::OP_TICK))
		else $error("expiry pending outside a tick");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten");

endmodule
`default_nettype wire

### sv/timer_min_deadline_scheduler_core.sv
// Top level: timer deadline scheduler with decoupled decode queue and scan engine.
//
// Channel cmd takes one operation per transaction (start, stop, again, set
// repeat, tick with time). Channel rsp returns the results: one per
// non-tick operation, one per expiry (up to MAX_FIRE) for a tick (or a single done
// result when nothing is due); the final result of an operation has last set.
// The front end decodes and queues up to two operations; cmd.ready drops
// only when that queue is full.
// Steps: from acceptance on an idle block, a non-tick operation or a tick
// with nothing due passes dequeue, execute, a scan of all SLOT_COUNT slots,
// decide and result load before its result. For a tick, each expiry adds a
// fire step, a full rescan, a decide and a result load. Most of this time is
// spent in the earliest-deadline scan, which reads one slot per cycle
// through the single slot-store read port. The back end takes the next
// operation only once the last result of the current one is loaded.
// Reset clears the queue, the armed and started flags, the time and the
// order counter; deadlines and intervals are never read before written.
// When rsp is stalled the result register holds and the back end waits,
// while the front end keeps taking operations into its queue.
`timescale 1ns / 1ps
`default_nettype none
module timer_min_deadline_scheduler_core #(
	parameter int SLOT_COUNT = tmds_pkg::SLOT_COUNT_DEF,
	parameter int TIME_BITS  = tmds_pkg::TIME_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tmds_in_if.sink    cmd,
	tmds_out_if.source rsp
);
	tmds_pkg::cmd_t q_cmd;
	logic           q_valid, q_pop;

	tmds_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_cmd   (q_cmd),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	tmds_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.TIME_BITS  (TIME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_cmd),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire
